/* hw/rtl/bphc_pkg.sv */
package bphc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_PRESSED    = 3'd1,
    ST_SHORT_HOLD = 3'd2,
    ST_LONG_HOLD  = 3'd3,
    ST_RELEASED   = 3'd4
  } btn_state_t;

  // Configuration register indexes.
  localparam logic CFG_READ_INTERVAL = 1'b0;
  localparam logic CFG_HOLD_LIMIT    = 1'b1;

  localparam logic [7:0] READ_INTERVAL_RESET = 8'h00;
  localparam logic [3:0] HOLD_LIMIT_RESET    = 4'hF;

  // Only this many buttons have a pin and a slot in the packed result.
  localparam int PIN_COUNT = 8;

  typedef struct packed {
    logic [7:0] pin_levels;
    logic [2:0] query_index;
  } in_item_t;

  typedef struct packed {
    logic        sampled;
    logic [23:0] all_states;
    logic [2:0]  queried_state;
  } out_item_t;

  // Control shared by all lanes for one tick.
  typedef struct packed {
    logic       sample_en;
    logic [3:0] hold_limit;
  } lane_ctrl_t;

endpackage

/* hw/rtl/bphc_lane.sv */
module bphc_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bphc_pkg::lane_ctrl_t   ctrl,
  input  logic                   pressed_now,
  output bphc_pkg::btn_state_t   state_nxt
);

  logic                 prev_r;
  logic [3:0]           count_r;
  bphc_pkg::btn_state_t state_r;

  logic                 prev_nxt;
  logic [3:0]           count_nxt;
  bphc_pkg::btn_state_t class_c;
  logic [3:0]           count_c;

  always_comb begin
    count_c = count_r;
    priority if (!prev_r && pressed_now) begin
      class_c = bphc_pkg::ST_PRESSED;
    end else if (prev_r && pressed_now) begin
      if (count_r >= ctrl.hold_limit) begin
        class_c = bphc_pkg::ST_LONG_HOLD;
      end else begin
        class_c = bphc_pkg::ST_SHORT_HOLD;
        count_c = count_r + 4'd1;
      end
    end else if (prev_r && !pressed_now) begin
      class_c = bphc_pkg::ST_RELEASED;
      count_c = 4'd0;
    end else begin
      class_c = bphc_pkg::ST_IDLE;
    end

    if (ctrl.sample_en) begin
      state_nxt = class_c;
      count_nxt = count_c;
      prev_nxt  = pressed_now;
    end else begin
      state_nxt = state_r;
      count_nxt = count_r;
      prev_nxt  = prev_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      count_r <= 4'd0;
      state_r <= bphc_pkg::ST_IDLE;
    end else begin
      prev_r  <= prev_nxt;
      count_r <= count_nxt;
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/bphc_merge.sv */
module bphc_merge #(
  parameter int NUM_BUTTONS = 8
) (
  input  bphc_pkg::btn_state_t states [NUM_BUTTONS],
  input  logic                 sampled,
  input  logic [2:0]           query_index,
  output bphc_pkg::out_item_t  result
);

  logic [23:0] packed_c;
  logic [2:0]  query_c;

  // Slots without a button stay zero.
  for (genvar i = 0; i < bphc_pkg::PIN_COUNT; i++) begin : g_pack
    if (i < NUM_BUTTONS) begin : g_used
      assign packed_c[3*i +: 3] = states[i];
    end else begin : g_unused
      assign packed_c[3*i +: 3] = 3'd0;
    end
  end

  // A query beyond the last button reads as idle.
  always_comb begin
    query_c = bphc_pkg::ST_IDLE;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if ({1'b0, query_index} == 4'(i)) begin
        query_c = states[i];
      end
    end
  end

  assign result.sampled       = sampled;
  assign result.all_states    = packed_c;
  assign result.queried_state = query_c;

endmodule

/* hw/rtl/button_press_hold_classifier.sv */
// A result item is loaded into the output register when its input item is accepted.
// Throughput: one item per cycle while in_stall is low.
// The input stalls only while a finished result waits and the output side stalls.
// Reset (rst_n low, synchronous): divider, hold counters, levels and states clear,
// read_interval returns to 0, hold_limit to 15 and the output register empties.
module button_press_hold_classifier #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bphc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bphc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata
);

  logic [7:0] read_interval_r;
  logic [3:0] hold_limit_r;
  logic [7:0] tick_r;
  logic [7:0] tick_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  bphc_pkg::out_item_t out_item_r;

  logic                  accept;
  logic                  sample_tick;
  bphc_pkg::lane_ctrl_t  lane_ctrl;
  bphc_pkg::btn_state_t  states_nxt [NUM_BUTTONS];
  bphc_pkg::out_item_t   result_c;

  // The output register frees itself when its item is taken, so a new item
  // can enter in the same cycle the old one leaves.
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // The divider samples once every read_interval+1 ticks. If the interval
  // was lowered below the running count, the next tick samples at once.
  assign sample_tick = (tick_r >= read_interval_r);

  always_comb begin
    tick_nxt = tick_r;
    if (accept) begin
      tick_nxt = sample_tick ? 8'd0 : tick_r + 8'd1;
    end
  end

  assign lane_ctrl.sample_en  = accept & sample_tick;
  assign lane_ctrl.hold_limit = hold_limit_r;

  // One lane per button. Pins are active low; buttons past the pin count
  // never see a press.
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic pressed_now;
    if (i < bphc_pkg::PIN_COUNT) begin : g_pin
      assign pressed_now = ~in_data.pin_levels[i];
    end else begin : g_nopin
      assign pressed_now = 1'b0;
    end

    bphc_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (lane_ctrl),
      .pressed_now (pressed_now),
      .state_nxt   (states_nxt[i])
    );
  end

  // The merge stage packs the states each lane will hold after this tick and
  // picks out the queried one.
  bphc_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .states      (states_nxt),
    .sampled     (sample_tick),
    .query_index (in_data.query_index),
    .result      (result_c)
  );

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_interval_r <= bphc_pkg::READ_INTERVAL_RESET;
      hold_limit_r    <= bphc_pkg::HOLD_LIMIT_RESET;
      tick_r          <= 8'd0;
      out_valid_r     <= 1'b0;
    end else begin
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          bphc_pkg::CFG_READ_INTERVAL: read_interval_r <= cfg_wdata;
          bphc_pkg::CFG_HOLD_LIMIT:    hold_limit_r    <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  // The result payload carries no reset; it is loaded with each accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= result_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

/* tb/button_press_hold_classifier_test.sv */
`timescale 1ns / 1ps

module button_press_hold_classifier_test;

  // A directed row either sends one tick or writes one register.
  typedef enum logic {
    ROW_TICK,
    ROW_WRITE
  } row_kind_t;

  typedef struct {
    row_kind_t            kind;
    bphc_pkg::in_item_t   tick;
    logic                 reg_index;
    logic [7:0]           reg_value;
    bit                   typed;
    bphc_pkg::out_item_t  typed_result;
  } stim_row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  bphc_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b1;
  bphc_pkg::out_item_t out_data;
  logic                cfg_we    = 1'b0;
  logic                cfg_index = bphc_pkg::CFG_READ_INTERVAL;
  logic [7:0]          cfg_wdata = '0;

  button_press_hold_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Percentages that shape the traffic on the two channels.
  int sender_idle_pct   = 25;
  int receiver_stall_pct = 69;

  // Our own copy of the classifier: configuration, tick divider and one lane
  // per button.
  logic [7:0]           read_interval_q;
  logic [3:0]           hold_limit_q;
  logic [7:0]           divider_q;
  logic [3:0]           hold_count [bphc_pkg::PIN_COUNT];
  logic                 held       [bphc_pkg::PIN_COUNT];
  bphc_pkg::btn_state_t button_q   [bphc_pkg::PIN_COUNT];

  // Reports the block owes us, oldest first.
  bphc_pkg::out_item_t predicted_reports[$];

  int mismatch_count  = 0;
  int reports_checked = 0;
  int sample_ticks    = 0;
  int long_hold_seen  = 0;
  int settings_used   = 0;

  // Advances the copy of the block by one tick and returns the report it must give.
  function automatic bphc_pkg::out_item_t classify_tick(bphc_pkg::in_item_t item);
    bphc_pkg::out_item_t report;
    logic                pressed_now;
    report = '0;
    if (divider_q < read_interval_q) begin
      divider_q = divider_q + 8'd1;
    end else begin
      // A sample tick: every lane compares its last level with the new one.
      divider_q = '0;
      report.sampled = 1'b1;
      for (int i = 0; i < bphc_pkg::PIN_COUNT; i++) begin
        pressed_now = ~item.pin_levels[i];
        if (!held[i] && pressed_now) begin
          button_q[i] = bphc_pkg::ST_PRESSED;
        end else if (held[i] && pressed_now) begin
          // The counter stops once it reaches the limit, and also stays put if the limit dropped below it.
          if (hold_count[i] >= hold_limit_q) begin
            button_q[i] = bphc_pkg::ST_LONG_HOLD;
          end else begin
            button_q[i] = bphc_pkg::ST_SHORT_HOLD;
            hold_count[i] = hold_count[i] + 4'd1;
          end
        end else if (held[i] && !pressed_now) begin
          button_q[i] = bphc_pkg::ST_RELEASED;
          hold_count[i] = '0;
        end else begin
          button_q[i] = bphc_pkg::ST_IDLE;
        end
        held[i] = pressed_now;
      end
    end
    // Between samples the report simply repeats the states of the last sample.
    for (int i = 0; i < bphc_pkg::PIN_COUNT; i++) begin
      report.all_states[3*i +: 3] = button_q[i];
    end
    report.queried_state = button_q[item.query_index];
    return report;
  endfunction

  // The output side stalls at random; a report is taken when valid and not stalled.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    bphc_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected report: sampled=%0b states=%06h queried=%0d",
                   out_data.sampled, out_data.all_states, out_data.queried_state);
        end
      end else begin
        want = predicted_reports.pop_front();
        reports_checked++;
        if (out_data.sampled !== want.sampled ||
            out_data.all_states !== want.all_states ||
            out_data.queried_state !== want.queried_state) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Report %0d: expected sampled=%0b states=%06h queried=%0d,",
                     reports_checked, want.sampled, want.all_states, want.queried_state);
            $display("  got sampled=%0b states=%06h queried=%0d",
                     out_data.sampled, out_data.all_states, out_data.queried_state);
          end
        end
      end
    end
  end

  // Offers one tick, with random idle cycles ahead of it, and records the report it
  // must produce once the block takes it. Valid stays high after acceptance so that
  // back-to-back ticks need no second assignment in one time step.
  task automatic send_tick(input bphc_pkg::in_item_t item, input bit typed,
                           input bphc_pkg::out_item_t typed_result);
    bphc_pkg::out_item_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(posedge clk);
    end while (in_stall);
    predicted = classify_tick(item);
    if (predicted.sampled) sample_ticks++;
    if (predicted.queried_state == bphc_pkg::ST_LONG_HOLD) long_hold_seen++;
    predicted_reports.push_back(typed ? typed_result : predicted);
  endtask

  // Registers change only with nothing in flight: stop sending and let every report out.
  // A tick always yields a report, so an empty queue means the block is idle.
  task automatic drain;
    in_valid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(input logic index, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == bphc_pkg::CFG_READ_INTERVAL) begin
      read_interval_q = value;
    end else begin
      hold_limit_q = value[3:0];
    end
    @(posedge clk);
  endtask

  function automatic stim_row_t tick_row(input logic [7:0] pins, input logic [2:0] query);
    stim_row_t row;
    row = '{ROW_TICK, '{pins, query}, bphc_pkg::CFG_READ_INTERVAL, 8'd0, 1'b0, '0};
    return row;
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] pins, input logic [2:0] query,
                                          input logic [23:0] states,
                                          input bphc_pkg::btn_state_t queried);
    stim_row_t row;
    row = '{ROW_TICK, '{pins, query}, bphc_pkg::CFG_READ_INTERVAL, 8'd0, 1'b1,
            '{1'b1, states, queried}};
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic index, input logic [7:0] value);
    stim_row_t row;
    row = '{ROW_WRITE, '0, index, value, 1'b0, '0};
    return row;
  endfunction

  stim_row_t directed_rows[$];

  initial begin
    logic [7:0]         interval_plan [8];
    logic [3:0]         limit_plan    [8];
    logic [7:0]         pin_pattern;
    int                 roll;
    bphc_pkg::in_item_t item;

    // Matches the block's state right after reset.
    read_interval_q = bphc_pkg::READ_INTERVAL_RESET;
    hold_limit_q    = bphc_pkg::HOLD_LIMIT_RESET;
    divider_q       = '0;
    for (int i = 0; i < bphc_pkg::PIN_COUNT; i++) begin
      hold_count[i] = '0;
      held[i]       = 1'b0;
      button_q[i]   = bphc_pkg::ST_IDLE;
    end

    // Out of reset every tick samples, so the first rows read straight off the state
    // codes: nothing pressed, all pressed, all holding, all released, back to idle.
    directed_rows.push_back(typed_row(8'hFF, 3'd0, '0, bphc_pkg::ST_IDLE));
    directed_rows.push_back(typed_row(8'h00, 3'd7, {8{bphc_pkg::ST_PRESSED}},
                                      bphc_pkg::ST_PRESSED));
    directed_rows.push_back(typed_row(8'h00, 3'd3, {8{bphc_pkg::ST_SHORT_HOLD}},
                                      bphc_pkg::ST_SHORT_HOLD));
    directed_rows.push_back(typed_row(8'hFF, 3'd5, {8{bphc_pkg::ST_RELEASED}},
                                      bphc_pkg::ST_RELEASED));
    directed_rows.push_back(typed_row(8'hFF, 3'd0, '0, bphc_pkg::ST_IDLE));
    // A zero hold limit turns the first continued hold into a long hold.
    directed_rows.push_back(write_row(bphc_pkg::CFG_HOLD_LIMIT, 8'd0));
    directed_rows.push_back(typed_row(8'hFE, 3'd0, {21'd0, bphc_pkg::ST_PRESSED},
                                      bphc_pkg::ST_PRESSED));
    directed_rows.push_back(typed_row(8'hFE, 3'd0, {21'd0, bphc_pkg::ST_LONG_HOLD},
                                      bphc_pkg::ST_LONG_HOLD));
    // Hold the top button up to a limit of two, then drop the limit below the count.
    directed_rows.push_back(write_row(bphc_pkg::CFG_HOLD_LIMIT, 8'd2));
    directed_rows.push_back(tick_row(8'h7F, 3'd7));
    directed_rows.push_back(tick_row(8'h7F, 3'd7));
    directed_rows.push_back(tick_row(8'h7F, 3'd7));
    directed_rows.push_back(tick_row(8'h7F, 3'd7));
    directed_rows.push_back(write_row(bphc_pkg::CFG_HOLD_LIMIT, 8'd1));
    directed_rows.push_back(tick_row(8'h7F, 3'd7));
    // Widest interval: ticks pass without a sample and report the held states.
    directed_rows.push_back(write_row(bphc_pkg::CFG_READ_INTERVAL, 8'd255));
    directed_rows.push_back(tick_row(8'h00, 3'd0));
    directed_rows.push_back(tick_row(8'h00, 3'd1));
    directed_rows.push_back(tick_row(8'h00, 3'd2));
    // Lowering the interval under the running divider forces a sample on the next tick.
    directed_rows.push_back(write_row(bphc_pkg::CFG_READ_INTERVAL, 8'd1));
    directed_rows.push_back(tick_row(8'h00, 3'd4));
    directed_rows.push_back(tick_row(8'hFF, 3'd6));
    directed_rows.push_back(tick_row(8'hFF, 3'd6));
    directed_rows.push_back(write_row(bphc_pkg::CFG_READ_INTERVAL, 8'd0));
    directed_rows.push_back(write_row(bphc_pkg::CFG_HOLD_LIMIT, 8'd15));
    directed_rows.push_back(tick_row(8'hAA, 3'd7));
    directed_rows.push_back(tick_row(8'h55, 3'd0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        drain();
        write_register(directed_rows[r].reg_index, directed_rows[r].reg_value);
      end else begin
        send_tick(directed_rows[r].tick, directed_rows[r].typed,
                  directed_rows[r].typed_result);
      end
    end
    settings_used = 4;

    // Random phases, each under its own register setting. Small intervals dominate so
    // that holds run long enough to reach the limit; the widest interval gets one phase.
    interval_plan = '{8'd0, 8'd0, 8'd1, 8'd255, 8'd2, 8'd0, 8'd3,
                      8'($urandom_range(255))};
    limit_plan    = '{4'd15, 4'd0, 4'd3, 4'd7, 4'd1, 4'd5, 4'd15,
                      4'($urandom_range(15))};
    pin_pattern   = 8'hFF;
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      if (phase < 3) begin
        sender_idle_pct    = 25;
        receiver_stall_pct = 69;
      end else if (phase < 6) begin
        sender_idle_pct    = 69;
        receiver_stall_pct = 25;
      end else begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      write_register(bphc_pkg::CFG_READ_INTERVAL, interval_plan[phase]);
      write_register(bphc_pkg::CFG_HOLD_LIMIT, {4'd0, limit_plan[phase]});
      settings_used++;
      for (int n = 0; n < 205; n++) begin
        // Buttons mostly stay as they were, so presses turn into holds; now and then
        // one button changes, and a few ticks carry an arbitrary bounce pattern.
        roll = $urandom_range(99);
        if (roll < 5) begin
          pin_pattern = 8'($urandom);
        end else if (roll < 20) begin
          pin_pattern = pin_pattern ^ (8'd1 << $urandom_range(7));
        end
        item.pin_levels  = pin_pattern;
        item.query_index = 3'($urandom_range(7));
        send_tick(item, 1'b0, '0);
      end
    end

    drain();
    repeat (4) @(posedge clk);

    $display("Checked %0d reports under %0d register settings.",
             reports_checked, settings_used);
    $display("They held %0d sample ticks and %0d long holds queried.",
             sample_ticks, long_hold_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad reports in total.", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake; a correct run ends far sooner.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
